// ===== hdl/pwm_capture_measure_unit_macros.svh =====
// Assertion helpers shared by the measurement unit.
`ifndef PWM_CAPTURE_MEASURE_UNIT_MACROS_SVH
`define PWM_CAPTURE_MEASURE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwm capture measure: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwm capture measure: next-cycle check failed");

`endif

// ===== hdl/pcm_pkg.sv =====
`default_nettype none

package pcm_pkg;

  localparam int STAMP_BITS = 16;

  localparam int TIME_W   = 16;
  localparam int STATUS_W = 2;
  localparam int DUTY_W   = 7;
  localparam int CLK_W    = 27;
  localparam int PS_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int SHIFT_W  = 4;

  localparam int DUTY_SCALE = 100;

  // The quotient unit must hold the clock, the scaled period and the scaled high time.
  localparam int DIV_W_A = (STAMP_BITS + 10 > CLK_W) ? STAMP_BITS + 10 : CLK_W;
  localparam int DIV_W   = (STAMP_BITS + 7 > DIV_W_A) ? STAMP_BITS + 7 : DIV_W_A;
  localparam int CNT_W   = $clog2(DIV_W + 1);

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_EDGE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ORDER   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_STOPPED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK    = 2'd1;

  localparam logic [PS_W-1:0] PS_DIV1    = 3'd1;
  localparam logic [PS_W-1:0] PS_DIV8    = 3'd2;
  localparam logic [PS_W-1:0] PS_DIV64   = 3'd3;
  localparam logic [PS_W-1:0] PS_DIV256  = 3'd4;
  localparam logic [PS_W-1:0] PS_DIV1024 = 3'd5;

  localparam logic [PS_W-1:0] PS_RESET = PS_DIV1;
  localparam logic [CLK_W-1:0] CLOCK_RESET = 27'd8000000;

  // Every prescale factor is a power of two, so the period is scaled by a shift.
  function automatic logic [SHIFT_W-1:0] prescale_shift(input logic [PS_W-1:0] code);
    logic [SHIFT_W-1:0] sh;
    case (code)
      PS_DIV1:    sh = '0;
      PS_DIV8:    sh = SHIFT_W'($clog2(8));
      PS_DIV64:   sh = SHIFT_W'($clog2(64));
      PS_DIV256:  sh = SHIFT_W'($clog2(256));
      PS_DIV1024: sh = SHIFT_W'($clog2(1024));
      default:    sh = '0;
    endcase
    return sh;
  endfunction

  function automatic logic prescale_stopped(input logic [PS_W-1:0] code);
    return !(code == PS_DIV1 || code == PS_DIV8 || code == PS_DIV64 ||
             code == PS_DIV256 || code == PS_DIV1024);
  endfunction

  typedef struct packed {
    logic cap_first;
    logic cap_fall;
    logic cap_last;
    logic div_start;
    logic div_sel_freq;
    logic save_duty;
    logic load_err;
    logic load_ok;
  } ctrl_cmd_t;

  typedef struct packed {
    logic err_order;
    logic err_stop;
    logic div_busy;
    logic div_done;
  } dp_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ===== hdl/pcm_if.sv =====
`default_nettype none

interface pcm_in_if;
  import pcm_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [TIME_W-1:0] edge_time;
  logic              edge_rising;
  modport source (output valid, output mode, output edge_time, output edge_rising,
                  input ready);
  modport sink   (input valid, input mode, input edge_time, input edge_rising,
                  output ready);
endinterface

interface pcm_out_if;
  import pcm_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TIME_W-1:0]   period_ticks;
  logic [TIME_W-1:0]   high_ticks;
  logic [DUTY_W-1:0]   duty_percent;
  logic [CLK_W-1:0]    freq_hz;
  modport source (output valid, output status, output period_ticks, output high_ticks,
                  output duty_percent, output freq_hz, input ready);
  modport sink   (input valid, input status, input period_ticks, input high_ticks,
                  input duty_percent, input freq_hz, output ready);
endinterface

interface pcm_cfg_if;
  import pcm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CLK_W-1:0]     data;
  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/pcm_div.sv =====
`default_nettype none

module pcm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pcm_pkg::DIV_W-1:0] num_i,
  input  logic [pcm_pkg::DIV_W-1:0] den_i,
  output pcm_pkg::div_status_t      status_o,
  output logic [pcm_pkg::DIV_W-1:0] quot_o
);
  import pcm_pkg::*;

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  // Restoring division, one quotient bit per cycle. Numerator bits leave the
  // top of quo_q while quotient bits enter at the bottom.
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, den_q};
    if (!diff[DIV_W]) begin
      rem_d = diff[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], 1'b1};
    end else begin
      rem_d = trial[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quo_q;

endmodule

`default_nettype wire

// ===== hdl/pcm_datapath.sv =====
`default_nettype none

module pcm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcm_pkg::ctrl_cmd_t            cmd_i,
  output pcm_pkg::dp_status_t           status_o,
  input  logic [pcm_pkg::TIME_W-1:0]    edge_time_i,
  input  logic                          cfg_we_i,
  input  logic [pcm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pcm_pkg::CLK_W-1:0]     cfg_data_i,
  output logic [pcm_pkg::STATUS_W-1:0]  status_field_o,
  output logic [pcm_pkg::TIME_W-1:0]    period_ticks_o,
  output logic [pcm_pkg::TIME_W-1:0]    high_ticks_o,
  output logic [pcm_pkg::DUTY_W-1:0]    duty_percent_o,
  output logic [pcm_pkg::CLK_W-1:0]     freq_hz_o
);
  import pcm_pkg::*;

  logic [PS_W-1:0]       prescale_q;
  logic [CLK_W-1:0]      clock_q;
  logic [STAMP_BITS-1:0] stamp;
  logic [STAMP_BITS-1:0] first_q, fall_q, last_q;
  logic [STAMP_BITS-1:0] period, high;
  logic [DUTY_W-1:0]     duty_q;
  logic [DIV_W-1:0]      div_num, div_den, quot;
  div_status_t           div_st;

  logic [STATUS_W-1:0]   status_q;
  logic [TIME_W-1:0]     period_q, high_q;
  logic [DUTY_W-1:0]     duty_out_q;
  logic [CLK_W-1:0]      freq_q;

  assign stamp  = STAMP_BITS'(edge_time_i);
  assign period = last_q - first_q;
  assign high   = fall_q - first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= PS_RESET;
      clock_q    <= CLOCK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PRESCALE: prescale_q <= cfg_data_i[PS_W-1:0];
        CFG_CLOCK:    clock_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_first) first_q <= stamp;
    if (cmd_i.cap_fall)  fall_q  <= stamp;
    if (cmd_i.cap_last)  last_q  <= stamp;
  end

  // Duty is computed first, then the frequency reuses the same divider.
  always_comb begin
    if (cmd_i.div_sel_freq) begin
      div_num = DIV_W'(clock_q);
      div_den = DIV_W'(period) << prescale_shift(prescale_q);
    end else begin
      div_num = DIV_W'(high) * DIV_W'(DUTY_SCALE);
      div_den = DIV_W'(period);
    end
  end

  pcm_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .status_o (div_st),
    .quot_o   (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_duty) duty_q <= DUTY_W'(quot);
    if (cmd_i.load_err) begin
      status_q   <= status_o.err_order ? STATUS_ORDER : STATUS_STOPPED;
      period_q   <= '0;
      high_q     <= '0;
      duty_out_q <= '0;
      freq_q     <= '0;
    end else if (cmd_i.load_ok) begin
      status_q   <= STATUS_OK;
      period_q   <= TIME_W'(period);
      high_q     <= TIME_W'(high);
      duty_out_q <= duty_q;
      freq_q     <= CLK_W'(quot);
    end
  end

  assign status_o.err_order = !(first_q < fall_q && fall_q < last_q);
  assign status_o.err_stop  = prescale_stopped(prescale_q);
  assign status_o.div_busy  = div_st.busy;
  assign status_o.div_done  = div_st.done;

  assign status_field_o = status_q;
  assign period_ticks_o = period_q;
  assign high_ticks_o   = high_q;
  assign duty_percent_o = duty_out_q;
  assign freq_hz_o      = freq_q;

endmodule

`default_nettype wire

// ===== hdl/pcm_ctrl.sv =====
`default_nettype none
`include "pwm_capture_measure_unit_macros.svh"

module pcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic                edge_rising_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pcm_pkg::ctrl_cmd_t  cmd_o,
  input  pcm_pkg::dp_status_t dp_status_i
);
  import pcm_pkg::*;

  typedef enum logic [1:0] {
    ST_CAPTURE,
    ST_EVAL,
    ST_DUTY,
    ST_FREQ
  } state_e;

  typedef enum logic [1:0] {
    PH_RISE1,
    PH_FALL,
    PH_RISE2,
    PH_IDLE
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   eval_err;

  // A closing edge would need the output register, so edges stall while
  // a result is still waiting there and the measurement is one edge away.
  assign in_ready_o = (state_q == ST_CAPTURE) && !(out_valid_q && phase_q == PH_RISE2);
  assign accept     = in_valid_i && in_ready_o;
  assign eval_err   = dp_status_i.err_order || dp_status_i.err_stop;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_CAPTURE: begin
        if (accept) begin
          if (mode_i == MODE_START) begin
            phase_d = PH_RISE1;
          end else if (phase_q == PH_RISE1 && edge_rising_i) begin
            cmd_o.cap_first = 1'b1;
            phase_d         = PH_FALL;
          end else if (phase_q == PH_FALL && !edge_rising_i) begin
            cmd_o.cap_fall = 1'b1;
            phase_d        = PH_RISE2;
          end else if (phase_q == PH_RISE2 && edge_rising_i) begin
            cmd_o.cap_last = 1'b1;
            phase_d        = PH_IDLE;
            state_d        = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (eval_err) begin
          cmd_o.load_err = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_CAPTURE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DUTY;
        end
      end
      ST_DUTY: begin
        if (dp_status_i.div_done) begin
          cmd_o.save_duty    = 1'b1;
          cmd_o.div_start    = 1'b1;
          cmd_o.div_sel_freq = 1'b1;
          state_d            = ST_FREQ;
        end
      end
      ST_FREQ: begin
        cmd_o.div_sel_freq = 1'b1;
        if (dp_status_i.div_done) begin
          cmd_o.load_ok = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_CAPTURE;
        end
      end
      default: begin
        state_d = ST_CAPTURE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CAPTURE;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PCM_ASSERT_SAME(a_no_result_during_eval, clk_i, rst_ni, state_q != ST_CAPTURE, !out_valid_q)
  `PCM_ASSERT_SAME(a_div_running, clk_i, rst_ni, state_q == ST_DUTY || state_q == ST_FREQ, dp_status_i.div_busy || dp_status_i.div_done)
  `PCM_ASSERT_NEXT(a_error_result, clk_i, rst_ni, state_q == ST_EVAL && eval_err, out_valid_q && state_q == ST_CAPTURE)
  `PCM_ASSERT_NEXT(a_freq_result, clk_i, rst_ni, state_q == ST_FREQ && dp_status_i.div_done, out_valid_q && state_q == ST_CAPTURE)

endmodule

`default_nettype wire

// ===== hdl/pwm_capture_measure_unit.sv =====
`default_nettype none
// Channel   Dir  Beat contents
// in_i      in   mode, edge_time, edge_rising
// out_o     out  status, period_ticks, high_ticks, duty_percent, freq_hz
// cfg_i     in   reg_index, data (0 prescale_select, 1 clock_hz)
//
// Start beats and edges that do not close a measurement are taken one per cycle unless the input stalls as below.
// A closing rising edge shows its result after the shared 27-bit divider, retiring one
// quotient bit per cycle, has worked out the duty and then the frequency; an order or
// stopped-prescaler error shows its result straight after the evaluation state.
// Reset is asynchronous and active low; the block idles until a start beat.
// Input stalls from a closing edge until its result is shown, and while a result
// waits in the output register with the measurement one edge from closing.
module pwm_capture_measure_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcm_in_if.sink    in_i,
  pcm_out_if.source out_o,
  pcm_cfg_if.sink   cfg_i
);
  import pcm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  assign cfg_i.ready = 1'b1;

  pcm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .mode_i        (in_i.mode),
    .edge_rising_i (in_i.edge_rising),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .cmd_o         (cmd),
    .dp_status_i   (dp_status)
  );

  pcm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .edge_time_i    (in_i.edge_time),
    .cfg_we_i       (cfg_i.valid && cfg_i.ready),
    .cfg_index_i    (cfg_i.reg_index),
    .cfg_data_i     (cfg_i.data),
    .status_field_o (out_o.status),
    .period_ticks_o (out_o.period_ticks),
    .high_ticks_o   (out_o.high_ticks),
    .duty_percent_o (out_o.duty_percent),
    .freq_hz_o      (out_o.freq_hz)
  );

endmodule

`default_nettype wire
